FILE: rtl/dbe_pkg.sv
// Shared types and constants for the detector background estimator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package dbe_pkg;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_HIT     = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_READ    = 2'd3
	} command_t;

	typedef enum logic {
		KIND_TOTAL   = 1'b0,
		KIND_READOUT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		MODE_FIRST = 2'd0,
		MODE_LATER = 2'd1,
		MODE_FINAL = 2'd2
	} walk_mode_t;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_PIX  = 8'd1;
	localparam logic [7:0]  MAX_ITER_RESET = 8'd10;
	localparam logic [23:0] INV_PIX_RESET  = 24'd21379;

	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 96;
	localparam int OUT_TUSER_W = 1;

	typedef struct packed {
		logic signed [24:0] bg;
		logic [15:0]        hits;
		logic [23:0]        expct;
	} entry_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic update;
		logic rd_mul;
		logic emit_rd;
		logic emit_tot;
		logic walk;
		logic next_pass;
		logic final_start;
		logic div_start;
	} ctrl_t;

	typedef struct packed {
		logic clear_done;
		logic walk_last;
		logic cont;
		logic div_done;
		logic out_free;
		logic side_ok;
	} stat_t;

endpackage
`default_nettype wire

FILE: rtl/dbe_controller.sv
// Sequencing state machine of the background estimator.
// Depends on dbe_pkg; drives the datapath only through ctrl_t and reads stat_t.
`default_nettype none
module dbe_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dbe_pkg::command_t in_command,
	output logic             in_ready,
	input  dbe_pkg::stat_t   stat,
	output dbe_pkg::ctrl_t   ctrl
);
	import dbe_pkg::*;

	typedef enum logic [11:0] {
		S_CLEAR   = 12'b000000000001,
		S_IDLE    = 12'b000000000010,
		S_UPDATE  = 12'b000000000100,
		S_RD_MUL  = 12'b000000001000,
		S_RD_EMIT = 12'b000000010000,
		S_WALK    = 12'b000000100000,
		S_DRAIN   = 12'b000001000000,
		S_DECIDE  = 12'b000010000000,
		S_DIV     = 12'b000100000000,
		S_FINAL   = 12'b001000000000,
		S_FDRAIN  = 12'b010000000000,
		S_EMIT    = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctrl.clear = 1'b1;
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					unique case (in_command) inside
						CMD_ADD, CMD_HIT: state_d = S_UPDATE;
						CMD_READ:         state_d = S_RD_MUL;
						default:          state_d = S_WALK;
					endcase
				end
			end
			S_UPDATE: begin
				ctrl.update = 1'b1;
				state_d     = S_IDLE;
			end
			S_RD_MUL: begin
				ctrl.rd_mul = 1'b1;
				state_d     = S_RD_EMIT;
			end
			S_RD_EMIT: begin
				if (stat.out_free) begin
					ctrl.emit_rd = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_WALK: begin
				if (!stat.side_ok) begin
					state_d = S_EMIT;
				end else begin
					ctrl.walk = 1'b1;
					if (stat.walk_last) state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_DECIDE;
			S_DECIDE: begin
				if (stat.cont) begin
					ctrl.div_start = 1'b1;
					state_d        = S_DIV;
				end else begin
					ctrl.final_start = 1'b1;
					state_d          = S_FINAL;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					ctrl.next_pass = 1'b1;
					state_d        = S_WALK;
				end
			end
			S_FINAL: begin
				ctrl.walk = 1'b1;
				if (stat.walk_last) state_d = S_FDRAIN;
			end
			S_FDRAIN: state_d = S_EMIT;
			S_EMIT: begin
				if (stat.out_free) begin
					ctrl.emit_tot = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/dbe_datapath.sv
// Datapath of the background estimator: entry memory, walk stage, divider,
// readout multiplier and result register. Depends on dbe_pkg.
`default_nettype none
module dbe_datapath #(
	parameter int DETECTORS_PER_SIDE = 256,
	parameter int SIDES              = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dbe_pkg::ctrl_t   ctrl,
	output dbe_pkg::stat_t   stat,
	input  dbe_pkg::command_t in_command,
	input  logic             in_detector,
	input  logic [7:0]       in_pd_index,
	input  logic [23:0]      in_photons,
	input  logic [15:0]      in_efficiency,
	input  logic [7:0]       max_iterations,
	input  logic [23:0]      inv_pixels_per_detector,
	input  logic             out_ready,
	output logic             out_valid,
	output dbe_pkg::kind_t   out_kind,
	output logic             out_detector,
	output logic [7:0]       out_pd,
	output logic [31:0]      out_total,
	output logic [23:0]      out_pd_background,
	output logic [23:0]      out_pixel_background
);
	import dbe_pkg::*;

	localparam int NENT      = SIDES * DETECTORS_PER_SIDE;
	localparam int EW        = $clog2(NENT);
	localparam int DW        = (DETECTORS_PER_SIDE > 2) ? $clog2(DETECTORS_PER_SIDE) : 1;
	localparam int KW        = $clog2(DETECTORS_PER_SIDE + 1);
	localparam int DIV_STEPS = 40;
	localparam int SW        = $clog2(DIV_STEPS);
	localparam logic signed [33:0] BKG_FLOOR = -34'sd16777216;

	entry_t mem_q [NENT];
	entry_t rdata_q;

	command_t        cmd_q;
	logic            det_q;
	logic [7:0]      pd_q;
	logic [EW-1:0]   ent_q;
	logic            inrange_q;
	logic            side_ok_q;
	logic [23:0]     prod_q;
	logic [EW-1:0]   cnt_q;
	walk_mode_t      mode_q;
	logic [8:0]      pass_q;
	logic [31:0]     corr_q;
	logic [39:0]     deficit_q;
	logic [KW-1:0]   below_q;
	logic [KW-1:0]   above_q;
	logic [31:0]     total_q;
	logic            vld_s1;
	logic [EW-1:0]   addr_s1;
	logic [47:0]     mul_q;
	logic [23:0]     pdbg_q;
	logic            div_busy_q;
	logic [SW-1:0]   dcnt_q;
	logic [39:0]     quo_q;
	logic [KW-1:0]   rem_q;

	logic [EW-1:0]   in_ent;
	logic            in_range;
	logic [EW-1:0]   walk_addr;
	logic [EW-1:0]   ra;
	logic            re;
	logic            we;
	logic [EW-1:0]   wa;
	entry_t          wd;
	entry_t          upd;
	logic [24:0]     esum;
	logic            pos_bg;
	logic signed [33:0] first_b, later_b, raw_b, clip_b, neg_b;
	logic [24:0]     new_bg;
	logic [24:0]     neg_mag;
	logic [32:0]     tsum;
	logic signed [25:0] diff;
	logic            pos_diff;
	logic [31:0]     px_wide;
	logic [KW:0]     div_sh;
	logic            div_ge;
	logic [KW-1:0]   div_rem;
	logic [39:0]     div_quo;

	// Entry address and range of the arriving item.
	assign in_range = (32'(in_detector) < SIDES) && (32'(in_pd_index) < DETECTORS_PER_SIDE);
	assign in_ent   = in_detector ? (EW'(DETECTORS_PER_SIDE) + EW'(in_pd_index))
	                              : EW'(in_pd_index);
	assign walk_addr = (det_q ? EW'(DETECTORS_PER_SIDE) : EW'(0)) + EW'(cnt_q[DW-1:0]);
	assign re = ctrl.load || ctrl.walk;
	assign ra = ctrl.load ? in_ent : walk_addr;

	// Read-modify-write value for accumulate and hit commands.
	always_comb begin
		upd  = rdata_q;
		esum = {1'b0, rdata_q.expct} + {1'b0, prod_q};
		if (cmd_q == CMD_ADD) begin
			upd.expct = esum[24] ? 24'hFFFFFF : esum[23:0];
		end else if (rdata_q.hits != 16'hFFFF) begin
			upd.hits = rdata_q.hits + 16'd1;
		end
	end

	// Walk stage: new background of the entry read in the previous cycle.
	always_comb begin
		pos_bg  = !rdata_q.bg[24] && (rdata_q.bg != '0);
		first_b = $signed({10'b0, rdata_q.hits, 8'b0}) - $signed({10'b0, rdata_q.expct});
		later_b = pos_bg ? ($signed({{9{rdata_q.bg[24]}}, rdata_q.bg})
		                    - $signed({2'b0, corr_q})) : '0;
		raw_b   = (mode_q == MODE_FIRST) ? first_b : later_b;
		clip_b  = (raw_b < BKG_FLOOR) ? BKG_FLOOR : raw_b;
		neg_b   = -clip_b;
		neg_mag = neg_b[24:0];
		if (rdata_q.hits == '0) begin
			new_bg = '0;
		end else if (mode_q == MODE_FINAL) begin
			new_bg = rdata_q.bg[24] ? 25'd0 : rdata_q.bg;
		end else begin
			new_bg = clip_b[24:0];
		end
		tsum = {1'b0, total_q} + {9'b0, new_bg[23:0]};
	end

	always_comb begin
		we = 1'b0;
		wa = addr_s1;
		wd = '{bg: new_bg, hits: rdata_q.hits, expct: rdata_q.expct};
		if (ctrl.clear) begin
			we = 1'b1;
			wa = cnt_q;
			wd = '0;
		end else if (ctrl.update && inrange_q) begin
			we = 1'b1;
			wa = ent_q;
			wd = upd;
		end else if (vld_s1) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem_q[ra];
		if (we) mem_q[wa] <= wd;
	end

	// Readout arithmetic.
	always_comb begin
		diff     = $signed({2'b0, rdata_q.hits, 8'b0}) - $signed({2'b0, rdata_q.expct});
		pos_diff = !diff[25] && (diff != '0);
		px_wide  = mul_q[47:16];
	end

	// Restoring divider step.
	always_comb begin
		div_sh  = {rem_q, quo_q[39]};
		div_ge  = div_sh >= {1'b0, above_q};
		div_rem = div_ge ? KW'(div_sh - {1'b0, above_q}) : div_sh[KW-1:0];
		div_quo = {quo_q[38:0], div_ge};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= in_command;
			det_q     <= in_detector;
			pd_q      <= in_pd_index;
			ent_q     <= in_ent;
			inrange_q <= in_range;
			side_ok_q <= 32'(in_detector) < SIDES;
			prod_q    <= 24'((in_photons * 40'(in_efficiency)) >> 16);
		end
		if (ctrl.rd_mul) begin
			mul_q  <= pos_diff ? (48'(diff[23:0]) * 48'(inv_pixels_per_detector)) : '0;
			pdbg_q <= (rdata_q.bg[24] || (rdata_q.bg == '0)) ? 24'd0 : rdata_q.bg[23:0];
		end
		if (ctrl.emit_rd || ctrl.emit_tot) begin
			out_kind             <= ctrl.emit_rd ? KIND_READOUT : KIND_TOTAL;
			out_detector         <= det_q;
			out_pd               <= ctrl.emit_rd ? pd_q : 8'd0;
			out_total            <= ctrl.emit_rd ? 32'd0 : total_q;
			out_pd_background    <= (ctrl.emit_rd && inrange_q) ? pdbg_q : 24'd0;
			out_pixel_background <= (!ctrl.emit_rd || !inrange_q) ? 24'd0 :
			                        (|px_wide[31:24]) ? 24'hFFFFFF : px_wide[23:0];
		end
		addr_s1 <= walk_addr;
		if (ctrl.div_start) begin
			quo_q <= deficit_q;
			rem_q <= '0;
		end else if (div_busy_q) begin
			quo_q <= div_quo;
			rem_q <= div_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			mode_q     <= MODE_FIRST;
			pass_q     <= 9'd1;
			corr_q     <= '0;
			deficit_q  <= '0;
			below_q    <= '0;
			above_q    <= '0;
			total_q    <= '0;
			vld_s1     <= 1'b0;
			out_valid  <= 1'b0;
			div_busy_q <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			vld_s1 <= ctrl.walk;
			if (ctrl.clear || ctrl.walk) begin
				cnt_q <= cnt_q + EW'(1);
			end else if (ctrl.load || ctrl.next_pass || ctrl.final_start) begin
				cnt_q <= '0;
			end
			if (ctrl.load) begin
				mode_q    <= MODE_FIRST;
				pass_q    <= 9'd1;
				corr_q    <= '0;
				total_q   <= '0;
				deficit_q <= '0;
				below_q   <= '0;
				above_q   <= '0;
			end else if (ctrl.next_pass) begin
				mode_q    <= MODE_LATER;
				pass_q    <= pass_q + 9'd1;
				deficit_q <= '0;
				below_q   <= '0;
				above_q   <= '0;
			end else if (ctrl.final_start) begin
				mode_q <= MODE_FINAL;
			end else if (vld_s1 && (rdata_q.hits != '0)) begin
				if (mode_q == MODE_FINAL) begin
					total_q <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
				end else if (clip_b < 0) begin
					below_q   <= below_q + KW'(1);
					deficit_q <= deficit_q + {15'b0, neg_mag};
				end else if (clip_b != 0) begin
					above_q <= above_q + KW'(1);
				end
			end
			if (ctrl.div_start) begin
				div_busy_q <= 1'b1;
				dcnt_q     <= SW'(DIV_STEPS - 1);
			end else if (div_busy_q) begin
				dcnt_q <= dcnt_q - SW'(1);
				if (dcnt_q == '0) begin
					div_busy_q <= 1'b0;
					corr_q     <= (|div_quo[39:32]) ? 32'hFFFFFFFF : div_quo[31:0];
				end
			end
			if (ctrl.emit_rd || ctrl.emit_tot) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.clear_done = cnt_q == EW'(NENT - 1);
		stat.walk_last  = cnt_q[DW-1:0] == DW'(DETECTORS_PER_SIDE - 1);
		stat.cont       = (below_q != '0) && (above_q != '0)
		                  && !(pass_q > {1'b0, max_iterations});
		stat.div_done   = !div_busy_q;
		stat.out_free   = !out_valid || out_ready;
		stat.side_ok    = side_ok_q;
	end

endmodule
`default_nettype wire

FILE: rtl/detector_background_estimator.sv
// Top level of the detector background estimator: stream ports, configuration
// registers and result packing. Depends on dbe_pkg, dbe_controller, dbe_datapath.
`default_nettype none
// The block keeps, per photodetector of each detector, an accumulated expected
// signal, a saturating hit count and a signed background in one memory of
// SIDES*DETECTORS_PER_SIDE entries. After reset a clearing pass writes every
// entry to zero, one per cycle, and no beat is taken on the input stream during
// it; configuration writes are always taken. Items are handled one at a time.
// An accumulate or hit beat reads the memory, then writes the entry back. A
// readout reads the entry, multiplies, then waits for the output register. A
// compute beat walks the detector's entries once per pass at one entry per cycle
// through the single memory read port; a pass that is followed by another adds a
// bit-serial 40-bit division of the deficit, and the closing clamp-and-sum walk
// hands the total to the output register. A result waits in the output register
// while the next beat is taken.
module detector_background_estimator #(
	parameter int DETECTORS_PER_SIDE = 256,
	parameter int SIDES              = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// detector[0], pd_index[8:1], photons[32:9], efficiency[48:33], zero above
	input  logic [dbe_pkg::IN_TDATA_W-1:0]      s_tdata,
	// command[1:0]
	input  logic [dbe_pkg::IN_TUSER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// detector_out[0], pd_out[8:1], total_background[40:9],
	// pd_background[64:41], pixel_background[88:65], zero above
	output logic [dbe_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// kind[0]
	output logic [dbe_pkg::OUT_TUSER_W-1:0]     m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dbe_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dbe_pkg::*;

	ctrl_t       ctrl;
	stat_t       stat;
	command_t    in_command;
	logic [7:0]  max_iter_q;
	logic [23:0] inv_pix_q;
	kind_t       out_kind;
	logic        out_detector;
	logic [7:0]  out_pd;
	logic [31:0] out_total;
	logic [23:0] out_pd_background;
	logic [23:0] out_pixel_background;

	// The configuration channel never stalls; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
			inv_pix_q  <= INV_PIX_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_ITER: max_iter_q <= cfg_data[7:0];
				REG_INV_PIX:  inv_pix_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_command = command_t'(s_tuser[1:0]);

	dbe_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (in_command),
		.in_ready   (s_tready),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	dbe_datapath #(
		.DETECTORS_PER_SIDE (DETECTORS_PER_SIDE),
		.SIDES              (SIDES)
	) u_dp (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.ctrl                    (ctrl),
		.stat                    (stat),
		.in_command              (in_command),
		.in_detector             (s_tdata[0]),
		.in_pd_index             (s_tdata[8:1]),
		.in_photons              (s_tdata[32:9]),
		.in_efficiency           (s_tdata[48:33]),
		.max_iterations          (max_iter_q),
		.inv_pixels_per_detector (inv_pix_q),
		.out_ready               (m_tready),
		.out_valid               (m_tvalid),
		.out_kind                (out_kind),
		.out_detector            (out_detector),
		.out_pd                  (out_pd),
		.out_total               (out_total),
		.out_pd_background       (out_pd_background),
		.out_pixel_background    (out_pixel_background)
	);

	// Result beat packing, first field in the lowest bits.
	assign m_tdata = {7'b0, out_pixel_background, out_pd_background, out_total,
	                  out_pd, out_detector};
	assign m_tuser = out_kind;

endmodule
`default_nettype wire

FILE: bench/detector_background_estimator_tb.sv
// Self-checking testbench for detector_background_estimator: accumulate, hit,
// compute and readout beats checked against an in-bench predictor.
// Depends on dbe_pkg and the RTL of the block only.
`default_nettype none
module detector_background_estimator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dbe_pkg::*;

	localparam int PDS     = 256;
	localparam int ENTRIES = 2 * PDS;
	// Cycles allowed after the last result for an accumulate or hit still in flight.
	localparam int SETTLE  = 12;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	always #5 clk = ~clk;

	detector_background_estimator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct packed {
		kind_t       kind;
		logic        det;
		logic [7:0]  pd;
		logic [31:0] total;
		logic [23:0] pd_bg;
		logic [23:0] pix_bg;
	} background_result_t;

	// Shadow of the block's state; backgrounds are wide integers for the arithmetic.
	logic [7:0]  max_iter_reg;
	logic [23:0] inv_pix_reg;
	logic [23:0] expected_sig [ENTRIES];
	logic [15:0] hit_count [ENTRIES];
	longint      background [ENTRIES];

	background_result_t pending_results[$];
	int mismatches = 0;
	int rx_hold = 0;        // long hold-off of the result side, in cycles
	bit rx_steady = 1'b0;   // result side always ready while set, unless a hold-off runs
	bit tx_steady = 1'b0;   // input side never pauses while set

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Iterative normalisation over the photodetectors of one detector that have
	// hits; returns the saturated total of the clamped backgrounds.
	function automatic logic [31:0] normalise_detector(int side);
		int     base;
		int     pass;
		int     below;
		int     above;
		bit     go;
		longint b;
		longint deficit;
		longint corr;
		longint sum;
		base = side * PDS;
		pass = 1;
		go = 1'b1;
		corr = 0;
		sum = 0;
		for (int i = 0; i < PDS; i++)
			if (hit_count[base + i] == 0)
				background[base + i] = 0;
		while (go) begin
			below = 0;
			above = 0;
			deficit = 0;
			for (int i = 0; i < PDS; i++) begin
				if (hit_count[base + i] != 0) begin
					if (pass == 1)
						b = (longint'(hit_count[base + i]) << 8)
							- longint'(expected_sig[base + i]);
					else
						b = background[base + i] > 0 ? background[base + i] - corr : 0;
					if (b < -64'sd16777216)
						b = -64'sd16777216;
					background[base + i] = b;
					if (b < 0) begin
						below++;
						deficit += -b;
					end else if (b > 0) begin
						above++;
					end
				end
			end
			if (below > 0 && above > 0) begin
				corr = deficit / above;
				if (corr > 64'hFFFF_FFFF)
					corr = 64'hFFFF_FFFF;
			end else begin
				go = 1'b0;
			end
			if (pass > max_iter_reg)
				go = 1'b0;
			pass++;
		end
		for (int i = 0; i < PDS; i++) begin
			if (hit_count[base + i] != 0) begin
				if (background[base + i] < 0)
					background[base + i] = 0;
				sum += background[base + i];
			end
		end
		return sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// Updates the shadow state for one accepted beat and queues its result.
	task automatic predict_beat(command_t cmd, logic det, logic [7:0] pd,
			logic [23:0] photons, logic [15:0] eff);
		int                 e;
		longint             acc;
		longint             diff;
		longint             px;
		background_result_t r;
		e = int'(det) * PDS + int'(pd);
		r = '0;
		r.det = det;
		case (cmd)
			CMD_ADD: begin
				acc = longint'(expected_sig[e]) + ((longint'(photons) * longint'(eff)) >> 16);
				expected_sig[e] = acc > 64'hFF_FFFF ? 24'hFF_FFFF : acc[23:0];
			end
			CMD_HIT: begin
				if (hit_count[e] != 16'hFFFF)
					hit_count[e]++;
			end
			CMD_COMPUTE: begin
				r.kind = KIND_TOTAL;
				r.total = normalise_detector(int'(det));
				pending_results.push_back(r);
			end
			default: begin
				r.kind = KIND_READOUT;
				r.pd = pd;
				diff = (longint'(hit_count[e]) << 8) - longint'(expected_sig[e]);
				r.pd_bg = background[e] > 0 ? background[e][23:0] : 24'd0;
				if (diff > 0) begin
					px = (diff * longint'(inv_pix_reg)) >> 16;
					r.pix_bg = px > 64'hFF_FFFF ? 24'hFF_FFFF : px[23:0];
				end
				pending_results.push_back(r);
			end
		endcase
	endtask

	// Offers one beat on the input stream and predicts it once it is taken.
	task automatic send_beat(command_t cmd, logic det, logic [7:0] pd,
			logic [23:0] photons, logic [15:0] eff);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, eff, photons, pd, det};
		do @(posedge clk); while (!s_tready);
		predict_beat(cmd, det, pd, photons, eff);
	endtask

	// Stops offering beats and waits until every expected result is back.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MAX_ITER)
			max_iter_reg = value[7:0];
		else if (idx == REG_INV_PIX)
			inv_pix_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stalls, a long hold-off on request.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if (rx_steady || pick_gap() == 0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
		end
	end

	// Each result beat is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		background_result_t got;
		background_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_t'(m_tuser[0]);
			got.det = m_tdata[0];
			got.pd = m_tdata[8:1];
			got.total = m_tdata[40:9];
			got.pd_bg = m_tdata[64:41];
			got.pix_bg = m_tdata[88:65];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result beat: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	// After reset two entries read back as zero and computes without hits sum to zero.
	task automatic test_after_reset();
		send_beat(CMD_READ, 1'b0, 8'd0, '0, '0);
		send_beat(CMD_READ, 1'b1, 8'd255, '0, '0);
		send_beat(CMD_COMPUTE, 1'b0, 8'd0, '0, '0);
		send_beat(CMD_COMPUTE, 1'b1, 8'd0, '0, '0);
		drain();
	endtask

	// Field extremes, saturated expected sum, pixel background at full and zero scale.
	task automatic test_extremes();
		write_reg(REG_INV_PIX, 24'hFF_FFFF);
		write_reg(REG_MAX_ITER, 8'd0);
		send_beat(CMD_ADD, 1'b1, 8'd255, 24'hFF_FFFF, 16'hFFFF);
		send_beat(CMD_ADD, 1'b1, 8'd255, 24'hFF_FFFF, 16'hFFFF);
		send_beat(CMD_READ, 1'b1, 8'd255, '0, '0);
		send_beat(CMD_ADD, 1'b0, 8'd7, 24'h00_0100, 16'h8000);
		repeat (3) send_beat(CMD_HIT, 1'b0, 8'd7, '0, '0);
		repeat (2) send_beat(CMD_HIT, 1'b0, 8'd9, '0, '0);
		send_beat(CMD_ADD, 1'b0, 8'd9, 24'h00_0400, 16'hFFFF);
		send_beat(CMD_HIT, 1'b1, 8'd255, '0, '0);
		send_beat(CMD_COMPUTE, 1'b0, 8'd0, '0, '0);
		send_beat(CMD_COMPUTE, 1'b1, 8'd0, '0, '0);
		send_beat(CMD_READ, 1'b0, 8'd7, '0, '0);
		send_beat(CMD_READ, 1'b0, 8'd9, '0, '0);
		send_beat(CMD_READ, 1'b1, 8'd255, '0, '0);
		send_beat(CMD_READ, 1'b0, 8'd128, 24'hFF_FFFF, 16'hFFFF);
		drain();
		write_reg(REG_INV_PIX, 24'd0);
		send_beat(CMD_READ, 1'b0, 8'd7, '0, '0);
		drain();
	endtask

	// One event on one detector: hits and expected signal near balance so that
	// the normalisation iterates, then a compute and a few readouts.
	task automatic run_event(logic det, int n_pds);
		logic [7:0] pd;
		for (int k = 0; k < n_pds; k++) begin
			pd = 8'($urandom_range(0, 255));
			repeat ($urandom_range(1, 3))
				send_beat(CMD_HIT, det, pd, 24'($urandom), 16'($urandom));
			repeat ($urandom_range(0, 2))
				send_beat(CMD_ADD, det, pd, 24'($urandom_range(0, 16'h3FF)),
					16'($urandom_range(16'h8000, 16'hFFFF)));
		end
		if ($urandom_range(0, 4) == 0)
			send_beat(command_t'($urandom_range(0, 1)), 1'($urandom), 8'($urandom),
				24'($urandom), 16'($urandom));
		send_beat(CMD_COMPUTE, det, 8'($urandom), 24'($urandom), 16'($urandom));
		repeat ($urandom_range(1, 4))
			send_beat(CMD_READ, det, 8'($urandom), 24'($urandom), 16'($urandom));
	endtask

	// Random phases, each under its own register setting.
	task automatic test_random_events();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: write_reg(REG_MAX_ITER, 8'd1);
				1: write_reg(REG_MAX_ITER, 8'd255);
				default: write_reg(REG_MAX_ITER, 8'($urandom_range(2, 20)));
			endcase
			write_reg(REG_INV_PIX, phase == 2 ? 24'hFF_FFFF : 24'($urandom));
			tx_steady = (phase == 3);
			rx_steady = (phase == 3);
			for (int n = 0; n < (phase == 1 ? 2 : 10); n++)
				run_event(1'($urandom), $urandom_range(2, 6));
			drain();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// The result side holds off while readouts keep coming, so the input stalls.
	task automatic test_backpressure();
		@(posedge clk);
		rx_hold = 300;
		repeat (20)
			send_beat(CMD_READ, 1'($urandom), 8'($urandom), 24'($urandom), 16'($urandom));
		drain();
	endtask

	initial begin
		max_iter_reg = MAX_ITER_RESET;
		inv_pix_reg = INV_PIX_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			expected_sig[i] = '0;
			hit_count[i] = '0;
			background[i] = 0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_after_reset();
		test_extremes();
		test_backpressure();
		test_random_events();
		drain();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
